// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/hml_pkg.sv =====
package hml_pkg;

  // Default number of grey levels handled by the tables.
  localparam int unsigned LEVELS_DEFAULT = 256;

  // Width of grey-level fields on the ports and of table entries.
  localparam int unsigned DATA_W = 8;

endpackage

// ===== rtl/histogram_matching_lut.sv =====
// Histogram matching through an inverse lookup table.
// Transactions: one command channel (start/busy) carries two kinds of transaction.
//   req_type_i = 0 loads reference entry entry_index_i with entry_value_i.
//   req_type_i = 1 maps pixel_in_i; the result shows on pixel_out_o with valid_o
//   high for exactly one cycle, the cycle after acceptance.
// A transaction is taken at a rising edge with start high and busy low.
// Pixels and ordinary loads do not raise busy, so a new transaction can be
// taken every cycle while busy is low. Loading the top entry (LEVELS-1) starts the
// table build and raises busy: a clear sweep over the inverse table, then for each
// of the LEVELS-1 neighbouring pairs a reference read and a span setup, plus one
// inverse write per entry in the pair's span, plus one final fix step.
// All of it runs on one address counter and one write port of the inverse table.
// Reset returns the sequencer to idle; the inverse table reads as zero until the
// first build completes (no clearing pass after reset). Reference entries read by a
// build must have been loaded. The receiver cannot stall: every result is
// presented once and is taken at the end of its cycle.
module histogram_matching_lut #(
  parameter int unsigned LEVELS = hml_pkg::LEVELS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type_i,
  input  logic [hml_pkg::DATA_W-1:0] entry_index_i,
  input  logic [hml_pkg::DATA_W-1:0] entry_value_i,
  input  logic [hml_pkg::DATA_W-1:0] pixel_in_i,
  output logic                      valid_o,
  output logic [hml_pkg::DATA_W-1:0] pixel_out_o
);

  localparam int unsigned DW = hml_pkg::DATA_W;
  // Table address width.
  localparam int unsigned AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  // Compare width: holds LEVELS itself and any data value.
  localparam int unsigned VW = ((AW > DW) ? AW : DW) + 1;

  localparam logic [VW-1:0] LEVELS_V = VW'(LEVELS);
  localparam logic [VW-1:0] TOP_V    = VW'(LEVELS - 1);
  localparam logic [AW-1:0] TOP_A    = AW'(LEVELS - 1);
  localparam logic [AW-1:0] PAIR_TOP = AW'(LEVELS - 2);

  // Build sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SET   = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_FIX   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;     // clear sweep / fill pointer
  logic [AW-1:0] hi_q, hi_d;       // last inverse entry of current span
  logic [AW-1:0] pair_q, pair_d;   // lower level of current pair
  logic [DW-1:0] prev_q, prev_d;   // reference value of upper level of pair
  logic          built_q, built_d; // inverse table holds a finished build
  logic          valid_q;
  logic          zero_q;           // force result to zero
  logic [DW-1:0] pix_rd_q;
  logic [DW-1:0] ref_rd_q;

  logic [DW-1:0] ref_mem [LEVELS];
  logic [DW-1:0] inv_mem [LEVELS];

  logic          accept;
  logic          load_acc;
  logic          pix_acc;
  logic [VW-1:0] idx_ext;
  logic [VW-1:0] pix_ext;
  logic          idx_ok;
  logic          ref_we;
  logic          ref_re;
  logic          inv_we;
  logic [AW-1:0] inv_wa;
  logic [DW-1:0] inv_wd;

  // Span setup of one pair (the shared compare unit).
  logic [VW-1:0] a_v;
  logic [VW-1:0] b_v;
  logic [VW-1:0] lo_v;
  logic [VW-1:0] hi_v;
  logic [VW-1:0] hi_c;
  logic [VW-1:0] lvl_v;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign load_acc = accept && !req_type_i;
  assign pix_acc  = accept && req_type_i;
  assign idx_ext  = VW'(entry_index_i);
  assign pix_ext  = VW'(pixel_in_i);
  assign idx_ok   = (idx_ext < LEVELS_V);
  assign ref_we   = load_acc && idx_ok;
  assign ref_re   = (state_q == ST_READ);

  assign a_v   = VW'(ref_rd_q);
  assign b_v   = VW'(prev_q);
  assign lo_v  = (a_v < b_v) ? a_v : b_v;
  assign hi_v  = (a_v < b_v) ? b_v : a_v;
  assign hi_c  = (hi_v > TOP_V) ? TOP_V : hi_v;
  // Upper level of the pair, kept to 8 bits when stored.
  assign lvl_v = VW'(pair_q) + VW'(1);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    hi_d    = hi_q;
    pair_d  = pair_q;
    prev_d  = prev_q;
    built_d = built_q;
    inv_we  = 1'b0;
    inv_wa  = ptr_q;
    inv_wd  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (ref_we && (idx_ext == TOP_V)) begin
          state_d = ST_CLEAR;
          ptr_d   = '0;
          pair_d  = PAIR_TOP;
          prev_d  = entry_value_i;
        end
      end
      ST_CLEAR: begin
        inv_we = 1'b1;
        if (ptr_q == TOP_A) begin
          ptr_d   = '0;
          state_d = ST_READ;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_READ: begin
        state_d = ST_SET;
      end
      ST_SET: begin
        prev_d = ref_rd_q;
        if (lo_v > hi_c) begin
          // empty span (both values beyond the table)
          if (pair_q == '0) begin
            state_d = ST_FIX;
          end else begin
            pair_d  = pair_q - AW'(1);
            state_d = ST_READ;
          end
        end else begin
          ptr_d   = lo_v[AW-1:0];
          hi_d    = hi_c[AW-1:0];
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        inv_we = 1'b1;
        inv_wd = lvl_v[DW-1:0];
        if (ptr_q == hi_q) begin
          if (pair_q == '0) begin
            state_d = ST_FIX;
          end else begin
            pair_d  = pair_q - AW'(1);
            state_d = ST_READ;
          end
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      ST_FIX: begin
        // reference level 0 mapped to 0: inverse entry 0 is 0
        inv_we  = (prev_q == '0);
        inv_wa  = '0;
        inv_wd  = '0;
        built_d = 1'b1;
        ptr_d   = '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      hi_q    <= '0;
      pair_q  <= '0;
      prev_q  <= '0;
      built_q <= 1'b0;
      valid_q <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      hi_q    <= hi_d;
      pair_q  <= pair_d;
      prev_q  <= prev_d;
      built_q <= built_d;
      valid_q <= pix_acc;
      if (pix_acc) begin
        zero_q <= !built_q || (pix_ext >= LEVELS_V);
      end
    end
  end

  // Reference table: load port and build read port.
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[idx_ext[AW-1:0]] <= entry_value_i;
    end
    if (ref_re) begin
      ref_rd_q <= ref_mem[pair_q];
    end
  end

  // Inverse table: build write port and pixel read port.
  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[inv_wa] <= inv_wd;
    end
    if (pix_acc) begin
      pix_rd_q <= inv_mem[pix_ext[AW-1:0]];
    end
  end

  assign valid_o     = valid_q;
  assign pixel_out_o = zero_q ? '0 : pix_rd_q;

`include "assert_macros.svh"

  `ASSERT_CLK(pixel_gives_result, pix_acc |=> valid_o, "pixel transaction without result")
  `ASSERT_CLK(top_load_starts_build, (ref_we && (idx_ext == TOP_V)) |=> busy, "top load did not start build")
  `ASSERT_NEVER(result_during_build, valid_o && busy, "result while build runs")
  `ASSERT_NEVER(fill_past_span, (state_q == ST_FILL) && (ptr_q > hi_q), "fill pointer beyond span")

endmodule
